FILE: sv/fastq_record_framer_core_macros.svh
// Assertion macros used by the FASTQ record framer parser.
`ifndef FASTQ_RECORD_FRAMER_CORE_MACROS_SVH
`define FASTQ_RECORD_FRAMER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define FQRF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fqrf assertion failed");
// Next-cycle implication, disabled during reset.
`define FQRF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fqrf assertion failed");
`else
`define FQRF_ASSERT_IMP(label, clk, rst, ante, cons)
`define FQRF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/fqrf_pkg.sv
// Shared constants and types for the FASTQ record framer.
package fqrf_pkg;

   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_NL   = 8'h0A;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_AT    = 2'd1;
   localparam logic [1:0] ERR_NO_NL    = 2'd2;
   localparam logic [1:0] ERR_READ_LEN = 2'd3;

   // Per-transaction status passed from the parser to the result register.
   typedef struct packed {
      logic       done;
      logic [1:0] error_code;
   } fqrf_status_type;

endpackage

FILE: sv/fastq_record_framer_core.sv
// Top level of the FASTQ record framer: input register, parser, result register.
// FASTQ record framer. Takes a FASTQ text stream one byte per transaction on
// the req_ channel and returns exactly one result transaction per byte on the
// rsp_ channel. rsp_record_done is high on the byte that closes a record (the
// last quality byte, or the plus-line newline when the read is empty), and
// then rsp_record_length (bytes from '@' through that byte, newlines counted,
// saturating) and rsp_read_length (sequence bytes, newlines excluded) are
// valid; otherwise both are zero. rsp_error_code carries the sticky error on
// every transaction: 0 none, 1 byte other than '@' or newline between records,
// 2 no newline after a record, 3 read longer than the read counter allows.
// Once set, the error holds and all later bytes are ignored until reset.
// Throughput is one byte per clock while rsp_ready stays high: a byte is
// registered in the input register on acceptance and then decoded by the
// parser; the parser state and the output register (rsp_valid included)
// update together when the byte advances, which waits on a held result.
// The output register lets a new byte be taken while a finished result is
// still waiting; req_ready drops only when both the input and result
// registers are full and rsp_ready is low.
module fastq_record_framer_core import fqrf_pkg::*; #(
   parameter int READ_LEN_BITS   = 16,
   parameter int RECORD_LEN_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_record_done,
   output logic [RECORD_LEN_BITS-1:0] rsp_record_length,
   output logic [READ_LEN_BITS-1:0]   rsp_read_length,
   output logic [1:0]                 rsp_error_code
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic advance;   // byte moves from input register into parser and result
   logic req_fire;

   fqrf_status_type            par_status, rsp_status;
   logic [RECORD_LEN_BITS-1:0] par_record_length;
   logic [READ_LEN_BITS-1:0]   par_read_length;

   assign advance     = in_valid_ff & (~rsp_valid | rsp_ready);
   assign req_ready   = ~in_valid_ff | advance;
   assign req_fire    = req_valid & req_ready;
   assign in_valid_in = req_fire | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_text_byte;
      end
   end

   fqrf_parser #(
      .READ_LEN_BITS  (READ_LEN_BITS),
      .RECORD_LEN_BITS(RECORD_LEN_BITS)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step_i         (advance),
      .text_byte_i    (in_byte_ff),
      .status_o       (par_status),
      .record_length_o(par_record_length),
      .read_length_o  (par_read_length)
   );

   fqrf_rsp_reg #(
      .READ_LEN_BITS  (READ_LEN_BITS),
      .RECORD_LEN_BITS(RECORD_LEN_BITS)
   ) u_rsp_reg (
      .clock          (clock),
      .reset          (reset),
      .load_i         (advance),
      .take_i         (rsp_ready),
      .status_i       (par_status),
      .record_length_i(par_record_length),
      .read_length_i  (par_read_length),
      .valid_o        (rsp_valid),
      .status_o       (rsp_status),
      .record_length_o(rsp_record_length),
      .read_length_o  (rsp_read_length)
   );

   assign rsp_record_done = rsp_status.done;
   assign rsp_error_code  = rsp_status.error_code;

endmodule

FILE: sv/fqrf_parser.sv
// Record parsing state machine and length counters.
`include "fastq_record_framer_core_macros.svh"
module fqrf_parser import fqrf_pkg::*; #(
   parameter int READ_LEN_BITS   = 16,
   parameter int RECORD_LEN_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_i,
   input  logic [7:0]                 text_byte_i,
   output fqrf_status_type            status_o,
   output logic [RECORD_LEN_BITS-1:0] record_length_o,
   output logic [READ_LEN_BITS-1:0]   read_length_o
);

   typedef enum logic [2:0] {
      PH_BETWEEN, PH_HEADER, PH_SEQ, PH_PLUS, PH_QUAL, PH_AFTER, PH_ERROR
   } phase_type;

   localparam logic [READ_LEN_BITS-1:0]   READ_MAX   = '1;
   localparam logic [RECORD_LEN_BITS-1:0] RECORD_MAX = '1;

   phase_type                  phase_ff, phase_in;
   logic [READ_LEN_BITS-1:0]   symbol_count_ff, symbol_count_in;
   logic [READ_LEN_BITS-1:0]   quality_left_ff, quality_left_in;
   logic [RECORD_LEN_BITS-1:0] byte_count_ff, byte_count_in;
   logic [1:0]                 sticky_error_ff, sticky_error_in;

   logic [RECORD_LEN_BITS-1:0] byte_count_inc;
   logic [READ_LEN_BITS-1:0]   quality_left_dec;
   logic                       done;
   logic                       is_nl;

   assign is_nl = (text_byte_i == CH_NL);
   // saturating record length
   assign byte_count_inc = (byte_count_ff == RECORD_MAX) ? byte_count_ff
                                                         : byte_count_ff + 1'b1;
   assign quality_left_dec = (quality_left_ff != '0) ? quality_left_ff - 1'b1
                                                      : quality_left_ff;

   always_comb begin
      phase_in        = phase_ff;
      symbol_count_in = symbol_count_ff;
      quality_left_in = quality_left_ff;
      byte_count_in   = byte_count_ff;
      sticky_error_in = sticky_error_ff;
      done            = 1'b0;
      case (phase_ff)
         PH_BETWEEN: begin
            if (text_byte_i == CH_AT) begin
               byte_count_in   = RECORD_LEN_BITS'(1);
               symbol_count_in = '0;
               quality_left_in = '0;
               phase_in        = PH_HEADER;
            end else if (!is_nl) begin
               sticky_error_in = ERR_NO_AT;
               phase_in        = PH_ERROR;
            end
         end
         PH_HEADER: begin
            byte_count_in = byte_count_inc;
            if (is_nl) phase_in = PH_SEQ;
         end
         PH_SEQ: begin
            if (text_byte_i == CH_PLUS) begin
               byte_count_in = byte_count_inc;
               phase_in      = PH_PLUS;
            end else if (is_nl) begin
               byte_count_in = byte_count_inc;
            end else if (symbol_count_ff == READ_MAX) begin
               sticky_error_in = ERR_READ_LEN;
               phase_in        = PH_ERROR;
            end else begin
               byte_count_in   = byte_count_inc;
               symbol_count_in = symbol_count_ff + 1'b1;
            end
         end
         PH_PLUS: begin
            byte_count_in = byte_count_inc;
            if (is_nl) begin
               if (symbol_count_ff == '0) begin
                  done     = 1'b1;
                  phase_in = PH_AFTER;
               end else begin
                  quality_left_in = symbol_count_ff;
                  phase_in        = PH_QUAL;
               end
            end
         end
         PH_QUAL: begin
            byte_count_in = byte_count_inc;
            if (!is_nl) begin
               quality_left_in = quality_left_dec;
               if (quality_left_dec == '0) begin
                  done     = 1'b1;
                  phase_in = PH_AFTER;
               end
            end
         end
         PH_AFTER: begin
            if (is_nl) begin
               phase_in = PH_BETWEEN;
            end else begin
               sticky_error_in = ERR_NO_NL;
               phase_in        = PH_ERROR;
            end
         end
         default: phase_in = PH_ERROR;
      endcase
   end

   assign status_o.done       = done;
   assign status_o.error_code = sticky_error_in;
   assign record_length_o     = done ? byte_count_in : '0;
   assign read_length_o       = done ? symbol_count_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_BETWEEN;
         symbol_count_ff <= '0;
         quality_left_ff <= '0;
         byte_count_ff   <= '0;
         sticky_error_ff <= ERR_NONE;
      end else if (step_i) begin
         phase_ff        <= phase_in;
         symbol_count_ff <= symbol_count_in;
         quality_left_ff <= quality_left_in;
         byte_count_ff   <= byte_count_in;
         sticky_error_ff <= sticky_error_in;
      end
   end

   `FQRF_ASSERT_NXT(a_error_sticky, clock, reset, sticky_error_ff != ERR_NONE, sticky_error_ff == $past(sticky_error_ff))
   `FQRF_ASSERT_IMP(a_done_clean, clock, reset, step_i && done, sticky_error_in == ERR_NONE && byte_count_in != '0)
   `FQRF_ASSERT_IMP(a_qual_idle, clock, reset, phase_ff != PH_QUAL, quality_left_ff == '0)

endmodule

FILE: sv/fqrf_rsp_reg.sv
// Result register that holds one transaction until the consumer takes it.
module fqrf_rsp_reg import fqrf_pkg::*; #(
   parameter int READ_LEN_BITS   = 16,
   parameter int RECORD_LEN_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load_i,
   input  logic                       take_i,
   input  fqrf_status_type            status_i,
   input  logic [RECORD_LEN_BITS-1:0] record_length_i,
   input  logic [READ_LEN_BITS-1:0]   read_length_i,
   output logic                       valid_o,
   output fqrf_status_type            status_o,
   output logic [RECORD_LEN_BITS-1:0] record_length_o,
   output logic [READ_LEN_BITS-1:0]   read_length_o
);

   logic                       valid_ff, valid_in;
   fqrf_status_type            status_ff;
   logic [RECORD_LEN_BITS-1:0] record_length_ff;
   logic [READ_LEN_BITS-1:0]   read_length_ff;

   assign valid_in = load_i | (valid_ff & ~take_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         status_ff        <= status_i;
         record_length_ff <= record_length_i;
         read_length_ff   <= read_length_i;
      end
   end

   assign valid_o         = valid_ff;
   assign status_o        = status_ff;
   assign record_length_o = record_length_ff;
   assign read_length_o   = read_length_ff;

endmodule

FILE: dv/fqrf_stream_checker.sv
// Checker for the FASTQ record framer: predicts every result and compares it.
module fqrf_stream_checker import fqrf_pkg::*; #(
   parameter int READ_LEN_BITS   = 16,
   parameter int RECORD_LEN_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [7:0]                 req_text_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_record_done,
   input  logic [RECORD_LEN_BITS-1:0] rsp_record_length,
   input  logic [READ_LEN_BITS-1:0]   rsp_read_length,
   input  logic [1:0]                 rsp_error_code,
   output int unsigned                fail_count,
   output int unsigned                pending_count,
   output int unsigned                records_done
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PH_BETWEEN, PH_HEADER, PH_SEQ, PH_PLUS, PH_QUAL, PH_AFTER, PH_ERROR
   } parse_phase_type;

   typedef struct packed {
      logic                       done;
      logic [RECORD_LEN_BITS-1:0] rec_len;
      logic [READ_LEN_BITS-1:0]   read_len;
      logic [1:0]                 err;
   } byte_outcome_type;

   // parser state as the block should hold it
   parse_phase_type            parse_phase    = PH_BETWEEN;
   logic [READ_LEN_BITS-1:0]   seq_symbols    = '0;
   logic [READ_LEN_BITS-1:0]   qual_remaining = '0;
   logic [RECORD_LEN_BITS-1:0] rec_bytes      = '0;
   logic [1:0]                 held_error     = ERR_NONE;

   byte_outcome_type outcomes_q[$];
   int unsigned      n_fail    = 0;
   int unsigned      n_records = 0;
   int unsigned      n_results = 0;

   function automatic void bump_rec_bytes();
      if (rec_bytes != '1) begin
         rec_bytes++;
      end
   endfunction

   function automatic void raise_error(input logic [1:0] code);
      held_error  = code;
      parse_phase = PH_ERROR;
   endfunction

   function automatic byte_outcome_type parse_byte(input logic [7:0] b);
      byte_outcome_type o;
      logic             closes;
      closes = 1'b0;
      case (parse_phase)
         PH_BETWEEN: begin
            if (b == CH_AT) begin
               rec_bytes      = RECORD_LEN_BITS'(1);
               seq_symbols    = '0;
               qual_remaining = '0;
               parse_phase    = PH_HEADER;
            end else if (b != CH_NL) begin
               raise_error(ERR_NO_AT);
            end
         end
         PH_HEADER: begin
            bump_rec_bytes();
            if (b == CH_NL) begin
               parse_phase = PH_SEQ;
            end
         end
         PH_SEQ: begin
            if (b == CH_PLUS) begin
               bump_rec_bytes();
               parse_phase = PH_PLUS;
            end else if (b == CH_NL) begin
               bump_rec_bytes();
            end else if (seq_symbols == '1) begin
               raise_error(ERR_READ_LEN);
            end else begin
               bump_rec_bytes();
               seq_symbols++;
            end
         end
         PH_PLUS: begin
            bump_rec_bytes();
            if (b == CH_NL) begin
               if (seq_symbols == '0) begin
                  closes      = 1'b1;
                  parse_phase = PH_AFTER;
               end else begin
                  qual_remaining = seq_symbols;
                  parse_phase    = PH_QUAL;
               end
            end
         end
         PH_QUAL: begin
            bump_rec_bytes();
            if (b != CH_NL) begin
               if (qual_remaining != '0) begin
                  qual_remaining--;
               end
               if (qual_remaining == '0) begin
                  closes      = 1'b1;
                  parse_phase = PH_AFTER;
               end
            end
         end
         PH_AFTER: begin
            if (b == CH_NL) begin
               parse_phase = PH_BETWEEN;
            end else begin
               raise_error(ERR_NO_NL);
            end
         end
         default: parse_phase = PH_ERROR;
      endcase
      o.done     = closes;
      o.rec_len  = closes ? rec_bytes : '0;
      o.read_len = closes ? seq_symbols : '0;
      o.err      = held_error;
      return o;
   endfunction

   task automatic report(input string what);
      n_fail++;
      if (n_fail <= 40) begin
         $display("[fqrf_chk] %0t mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      byte_outcome_type want;
      if (reset) begin
         parse_phase    = PH_BETWEEN;
         seq_symbols    = '0;
         qual_remaining = '0;
         rec_bytes      = '0;
         held_error     = ERR_NONE;
         outcomes_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            outcomes_q.push_back(parse_byte(req_text_byte));
         end
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (outcomes_q.size() == 0) begin
               report($sformatf("result %0d arrived with nothing outstanding", n_results));
            end else begin
               want = outcomes_q.pop_front();
               if (rsp_record_done !== want.done) begin
                  report($sformatf("result %0d record_done %b, predicted %b",
                                   n_results, rsp_record_done, want.done));
               end
               if (rsp_record_length !== want.rec_len) begin
                  report($sformatf("result %0d record_length 0x%h, predicted 0x%h",
                                   n_results, rsp_record_length, want.rec_len));
               end
               if (rsp_read_length !== want.read_len) begin
                  report($sformatf("result %0d read_length 0x%h, predicted 0x%h",
                                   n_results, rsp_read_length, want.read_len));
               end
               if (rsp_error_code !== want.err) begin
                  report($sformatf("result %0d error_code %0d, predicted %0d",
                                   n_results, rsp_error_code, want.err));
               end
               if (want.done) begin
                  n_records++;
               end
            end
         end
      end
      fail_count    <= n_fail;
      pending_count <= outcomes_q.size();
      records_done  <= n_records;
   end

endmodule

FILE: dv/tb_fastq_record_framer_core.sv
// Testbench top for the FASTQ record framer core: stimulus, idling and verdict.
module tb_fastq_record_framer_core import fqrf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int READ_LEN_BITS   = 16;
   localparam int RECORD_LEN_BITS = 20;
   localparam int RANDOM_BYTES    = 550;
   localparam logic [7:0] CH_CR   = 8'h0D;

   // how the run is closed: only one sticky error can be seen per reset
   typedef enum int { END_NO_AT, END_NO_NL } run_ending_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_text_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_record_done;
   logic [RECORD_LEN_BITS-1:0] rsp_record_length;
   logic [READ_LEN_BITS-1:0]   rsp_read_length;
   logic [1:0]                 rsp_error_code;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned records_done;

   // idling switch shared by the sender and the result-side stall generator
   bit          idle_en    = 1'b0;
   int unsigned bytes_sent = 0;

   fastq_record_framer_core #(
      .READ_LEN_BITS   (READ_LEN_BITS),
      .RECORD_LEN_BITS (RECORD_LEN_BITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_done   (rsp_record_done),
      .rsp_record_length (rsp_record_length),
      .rsp_read_length   (rsp_read_length),
      .rsp_error_code    (rsp_error_code)
   );

   fqrf_stream_checker #(
      .READ_LEN_BITS   (READ_LEN_BITS),
      .RECORD_LEN_BITS (RECORD_LEN_BITS)
   ) u_stream_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_done   (rsp_record_done),
      .rsp_record_length (rsp_record_length),
      .rsp_read_length   (rsp_read_length),
      .rsp_error_code    (rsp_error_code),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .records_done      (records_done)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop, set above the slowest legal run (a long final random record,
   // every transaction gapped and stalled, the bounded final wait).
   initial begin
      #1_000_000;
      $display("Timed out with %0d results outstanding", pending_count);
      $display("tb_fastq_record_framer_core: FAIL");
      $finish;
   end

   // Result side: random stall bursts while idling is on, otherwise
   // always ready.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One byte transaction. Valid is only dropped for a gap; after acceptance
   // it is left high so back-to-back bytes need just one assignment per edge.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   // Hold the sender off until every outstanding result has come back.
   // Always waits on a clock edge first, so valid is never re-raised in the
   // step it was dropped.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Line content: never a newline; '+' optional since it ends a sequence.
   // Mostly bases or printable quality, now and then CR or any byte at all.
   function automatic logic [7:0] pick_byte(input bit allow_plus, input bit printable);
      logic [7:0] b;
      string      bases;
      bases = "ACGTN";
      do begin
         case ($urandom_range(0, 15))
            0, 1:    b = 8'($urandom_range(0, 255));
            2:       b = CH_CR;
            default: b = printable ? 8'($urandom_range(33, 126)) : bases[$urandom_range(0, 4)];
         endcase
      end while (b == CH_NL || (!allow_plus && b == CH_PLUS));
      return b;
   endfunction

   // A well-formed record up to and including its closing byte; the caller
   // sends whatever follows. Sequence and quality get stray line breaks.
   task automatic send_record(input int hdr_len, input int seq_len);
      send_byte(CH_AT);
      for (int i = 0; i < hdr_len; i++) begin
         send_byte(pick_byte(1'b1, 1'b1));
      end
      send_byte(CH_NL);
      for (int i = 0; i < seq_len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte(CH_NL);
         end
         send_byte(pick_byte(1'b0, 1'b0));
      end
      send_byte(CH_PLUS);
      repeat ($urandom_range(0, 3)) send_byte(pick_byte(1'b1, 1'b1));
      send_byte(CH_NL);
      for (int i = 0; i < seq_len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte(CH_NL);
         end
         send_byte(pick_byte(1'b1, 1'b1));
      end
   endtask

   initial begin
      run_ending_type ending;
      int unsigned    directed_bytes;
      logic [7:0]     stray;
      int             seq_len;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: blank lines between records, an empty read closed on the
      // plus-line newline, then a header carrying 0xFF, 0x00 and CR, a split
      // sequence with '@' inside it and quality holding '+', '@' and a break.
      idle_en = 1'b1;
      send_text("\n\n@\n+\n\n");
      send_byte(CH_AT);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_text("\r\n@A\nC\n+x\n+@\n~\n");
      directed_bytes = bytes_sent;

      // sender held back until the pipeline is empty
      drain();

      // Random records. Idling is on for most of them, off for some, and now
      // and then the sender waits for the result side to empty.
      while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
         idle_en = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 15) == 0) begin
            drain();
         end
         seq_len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 12);
         send_record($urandom_range(0, 8), seq_len);
         send_byte(CH_NL);
         repeat ($urandom_range(0, 2)) send_byte(CH_NL);
      end

      // Last part: no idling from here on, a couple of ordinary records.
      idle_en = 1'b0;
      repeat (2) begin
         send_record($urandom_range(0, 4), $urandom_range(0, 6));
         send_byte(CH_NL);
      end

      // Close on one of the sticky errors.
      ending = run_ending_type'($urandom_range(0, 1));
      case (ending)
         END_NO_AT: begin
            do stray = 8'($urandom_range(0, 255)); while (stray == CH_NL || stray == CH_AT);
            send_byte(stray);
         end
         default: begin
            // half the time an empty read, so the bad byte follows the plus line
            send_record($urandom_range(0, 4),
                        $urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
            send_byte(pick_byte(1'b1, 1'b0));
         end
      endcase

      // everything after the error must be ignored, a whole record included
      repeat (12) send_byte(8'($urandom_range(0, 255)));
      send_text("@\n+\n\n");

      // Wait for the last results, bounded, then keep clocking to catch strays.
      req_valid <= 1'b0;
      for (int n = 0; n < 2000 && pending_count != 0; n++) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (pending_count != 0) begin
         $display("%0d results never arrived", pending_count);
      end
      $display("Run covered %0d byte transactions and %0d completed records,",
               bytes_sent, records_done);
      $display("with blank lines, empty reads and split lines, closed on error %s.",
               ending.name());
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_fastq_record_framer_core: PASS");
      end else begin
         $display("tb_fastq_record_framer_core: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/fqrf_pkg.sv
sv/fqrf_parser.sv
sv/fqrf_rsp_reg.sv
sv/fastq_record_framer_core.sv
dv/fqrf_stream_checker.sv
dv/tb_fastq_record_framer_core.sv
